// ----- src/transfer_function_interpolator_unit_defines.svh -----
// Assertion macros shared by the transfer function interpolator RTL.
// Depends on nothing; include by bare file name inside a module body.
`ifndef TRANSFER_FUNCTION_INTERPOLATOR_UNIT_DEFINES_SVH
`define TRANSFER_FUNCTION_INTERPOLATOR_UNIT_DEFINES_SVH

// same-cycle implication, quiet while reset is asserted
`define TFI_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tfi: same-cycle check failed");

// next-cycle implication, quiet while reset is asserted
`define TFI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tfi: next-cycle check failed");

`endif

// ----- src/tfi_pkg.sv -----
// Package for the transfer function interpolator: sizes, field widths,
// point, mode and state types, and the point store address helper. No dependencies.
`default_nettype none

package tfi_pkg;

    localparam int MAX_POINTS   = 16;
    localparam int NUM_CHANNELS = 4;

    localparam int X_W      = 8;
    localparam int Y_W      = 13;
    localparam int MODE_W   = 2;
    localparam int CH_W     = 2;
    localparam int NUM_W    = 21;
    localparam int REM_W    = 8;

    localparam int IN_DATA_W  = 24;
    localparam int IN_USER_W  = MODE_W + CH_W;
    localparam int OUT_DATA_W = 16;

    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int IDX_W  = $clog2(MAX_POINTS);
    localparam int CHI_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int DEPTH  = NUM_CHANNELS * MAX_POINTS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int DCNT_W = $clog2(NUM_W);

    localparam logic [Y_W-1:0] Q12_ONE   = Y_W'(4096);
    localparam logic [X_W-1:0] TOP_INDEX = X_W'(255);

    typedef enum logic [MODE_W-1:0] {
        MODE_CLEAR = 2'd0,
        MODE_ADD   = 2'd1,
        MODE_EVAL  = 2'd2
    } mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_ADD_CMP,
        ST_ADD_PUT,
        ST_EV_WALK,
        ST_EV_MUL0,
        ST_EV_MUL1,
        ST_EV_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [X_W-1:0] x;
        logic [Y_W-1:0] y;
    } point_t;

    function automatic logic [ADDR_W-1:0] ent_addr(input logic [CHI_W-1:0] ch,
                                                   input logic [IDX_W-1:0] k);
        return ADDR_W'(int'(ch) * MAX_POINTS + int'(k));
    endfunction

endpackage

`default_nettype wire

// ----- src/transfer_function_interpolator_unit.sv -----
// Transfer function interpolator top level: point store, insertion sort,
// segment walk and rounding divider. Depends on tfi_pkg and the defines header.
//
// Usage:
//   Input words arrive on s_axis; tuser carries mode and channel, tdata the
//   intensity (or table index) and the Q12 point value. Each word gives one
//   output word on m_axis: tdata holds the interpolated Q12 value for an
//   evaluate, tuser flags an add dropped because the channel was full.
//   Words are handled one at a time; s_axis_tready is high while the block is
//   idle, also while a finished output word still waits in the output register.
//   Path from acceptance to m_axis_tvalid (s_axis_tready rises with it):
//     clear, unused mode, empty channel, full channel: decode, then output;
//     add: decode, stored points shifted up one at a time, write, then output;
//     evaluate: decode, walk of the points and EV_MUL0, then output when the
//       value needs no division, else EV_MUL1 and the 21-step restoring
//       divider before output.
//   The point store is a single synchronous RAM with one read and one write per
//   cycle, one entry visited per cycle.
//   Reset empties all channels at once (counts only; no clearing pass).
//   While m_axis_tready is low the output word holds and the block finishes the
//   next word up to its output stage, then waits there.
`default_nettype none

module transfer_function_interpolator_unit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [7:0] intensity, [20:8] point_value, [23:21] zero
    input  wire logic [tfi_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // [1:0] mode, [3:2] channel
    input  wire logic [tfi_pkg::IN_USER_W-1:0]   s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [12:0] result_value, [15:13] zero
    output logic [tfi_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    // [0] status
    output logic                                 m_axis_tuser
);

    import tfi_pkg::*;

    `include "transfer_function_interpolator_unit_defines.svh"

    state_t state_reg, state_next;

    logic [MODE_W-1:0] cmd_mode_reg;
    logic [CH_W-1:0]   cmd_ch_reg;
    logic [X_W-1:0]    cmd_x_reg;
    logic [Y_W-1:0]    cmd_y_reg;

    logic [CNT_W-1:0]  count_reg [NUM_CHANNELS];
    logic [CNT_W-1:0]  count_next [NUM_CHANNELS];

    logic [IDX_W-1:0]  pos_reg, pos_next;
    logic [IDX_W-1:0]  k_reg, k_next;
    point_t            prev_reg, prev_next;
    point_t            left_reg, left_next;
    point_t            right_reg, right_next;
    logic [NUM_W-1:0]  acc_reg, acc_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [DCNT_W-1:0] dcnt_reg, dcnt_next;
    logic [Y_W-1:0]    res_value_reg, res_value_next;
    logic              res_status_reg, res_status_next;

    logic              out_valid_reg, out_valid_next;
    logic [Y_W-1:0]    out_value_reg, out_value_next;
    logic              out_status_reg, out_status_next;

    point_t            mem [DEPTH];
    point_t            rd_data_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    point_t            mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;

    logic              accept;
    logic              ch_ok;
    logic [CHI_W-1:0]  ch_idx;
    logic [CNT_W-1:0]  n_cur;
    logic              full;
    logic [Y_W-1:0]    y_sat;
    point_t            new_pt;
    logic              first;
    logic              hit;
    logic              last;
    logic              shift_up;
    logic              out_free;
    logic [X_W-1:0]    d;
    logic              trivial;
    logic [NUM_W-1:0]  mul_a;
    logic [NUM_W-1:0]  mul_b;
    logic [NUM_W-1:0]  product;
    logic [REM_W:0]    trial;
    logic              trial_ge;
    logic              cnt_in_range;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);

    assign ch_ok    = ({1'b0, cmd_ch_reg} < (CH_W + 1)'(NUM_CHANNELS));
    assign ch_idx   = cmd_ch_reg[CHI_W-1:0];
    assign n_cur    = ch_ok ? count_reg[ch_idx] : '0;
    assign full     = (n_cur >= CNT_W'(MAX_POINTS));
    assign y_sat    = (cmd_y_reg > Q12_ONE) ? Q12_ONE : cmd_y_reg;
    assign new_pt   = '{x: cmd_x_reg, y: y_sat};

    assign first    = (k_reg == '0);
    assign hit      = !(first && (rd_data_reg.x == '0)) && (rd_data_reg.x >= cmd_x_reg);
    assign last     = ((CNT_W'(k_reg) + CNT_W'(1)) == n_cur);
    assign shift_up = (rd_data_reg.x > cmd_x_reg);
    assign out_free = !out_valid_reg || m_axis_tready;

    assign d        = right_reg.x - left_reg.x;
    assign trivial  = (right_reg.x <= left_reg.x) || (cmd_x_reg <= left_reg.x)
                      || (cmd_x_reg >= right_reg.x);

    assign trial    = {rem_reg, acc_reg[NUM_W-1]};
    assign trial_ge = (trial >= {1'b0, d});

    always_comb
    begin
        if (state_reg == ST_EV_MUL0)
        begin
            mul_a = NUM_W'(right_reg.x - cmd_x_reg);
            mul_b = NUM_W'(left_reg.y);
        end
        else
        begin
            mul_a = NUM_W'(cmd_x_reg - left_reg.x);
            mul_b = NUM_W'(right_reg.y);
        end
        product = mul_a * mul_b;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_DECODE;
            end
            ST_DECODE:
            begin
                state_next = ST_OUT;
                if (ch_ok)
                begin
                    case (cmd_mode_reg)
                        MODE_ADD:
                        begin
                            if (!full && n_cur != '0)
                                state_next = ST_ADD_CMP;
                        end
                        MODE_EVAL:
                        begin
                            if (n_cur != '0)
                                state_next = ST_EV_WALK;
                        end
                        default:
                            state_next = ST_OUT;
                    endcase
                end
            end
            ST_ADD_CMP:
            begin
                if (!shift_up)
                    state_next = ST_OUT;
                else if (pos_reg == IDX_W'(1))
                    state_next = ST_ADD_PUT;
            end
            ST_ADD_PUT:
                state_next = ST_OUT;
            ST_EV_WALK:
            begin
                if (hit || last)
                    state_next = ST_EV_MUL0;
            end
            ST_EV_MUL0:
                state_next = trivial ? ST_OUT : ST_EV_MUL1;
            ST_EV_MUL1:
                state_next = ST_EV_DIV;
            ST_EV_DIV:
            begin
                if (dcnt_reg == DCNT_W'(NUM_W - 1))
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath, memory controls and outputs
    always_comb
    begin
        count_next      = count_reg;
        pos_next        = pos_reg;
        k_next          = k_reg;
        prev_next       = prev_reg;
        left_next       = left_reg;
        right_next      = right_reg;
        acc_next        = acc_reg;
        rem_next        = rem_reg;
        dcnt_next       = dcnt_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        mem_we          = 1'b0;
        mem_waddr       = ent_addr(ch_idx, pos_reg);
        mem_wdata       = new_pt;
        mem_raddr       = ent_addr(ch_idx, '0);

        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
            end
            ST_DECODE:
            begin
                res_value_next  = '0;
                res_status_next = 1'b0;
                pos_next        = n_cur[IDX_W-1:0];
                k_next          = '0;
                if (ch_ok)
                begin
                    case (cmd_mode_reg)
                        MODE_CLEAR:
                            count_next[ch_idx] = '0;
                        MODE_ADD:
                        begin
                            if (full)
                                res_status_next = 1'b1;
                            else if (n_cur == '0)
                            begin
                                mem_we             = 1'b1;
                                mem_waddr          = ent_addr(ch_idx, '0);
                                count_next[ch_idx] = CNT_W'(1);
                            end
                            else
                                mem_raddr = ent_addr(ch_idx, IDX_W'(n_cur - CNT_W'(1)));
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_ADD_CMP:
            begin
                // read of pos-2 and write of pos never meet on one entry
                if (shift_up)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = rd_data_reg;
                    pos_next  = pos_reg - IDX_W'(1);
                    mem_raddr = ent_addr(ch_idx, pos_reg - IDX_W'(2));
                end
                else
                begin
                    mem_we             = 1'b1;
                    count_next[ch_idx] = n_cur + CNT_W'(1);
                end
            end
            ST_ADD_PUT:
            begin
                mem_we             = 1'b1;
                count_next[ch_idx] = n_cur + CNT_W'(1);
            end
            ST_EV_WALK:
            begin
                if (hit)
                begin
                    left_next  = first ? point_t'{x: '0, y: rd_data_reg.y} : prev_reg;
                    right_next = rd_data_reg;
                end
                else
                begin
                    prev_next = rd_data_reg;
                    if (last)
                    begin
                        left_next  = rd_data_reg;
                        right_next = '{x: TOP_INDEX, y: rd_data_reg.y};
                    end
                    else
                    begin
                        k_next    = k_reg + IDX_W'(1);
                        mem_raddr = ent_addr(ch_idx, k_reg + IDX_W'(1));
                    end
                end
            end
            ST_EV_MUL0:
            begin
                if ((right_reg.x <= left_reg.x) || (cmd_x_reg <= left_reg.x))
                    res_value_next = left_reg.y;
                else if (cmd_x_reg >= right_reg.x)
                    res_value_next = right_reg.y;
                acc_next = product;
            end
            ST_EV_MUL1:
            begin
                acc_next  = acc_reg + product + NUM_W'(d >> 1);
                rem_next  = '0;
                dcnt_next = '0;
            end
            ST_EV_DIV:
            begin
                rem_next  = trial_ge ? REM_W'(trial - {1'b0, d}) : trial[REM_W-1:0];
                acc_next  = {acc_reg[NUM_W-2:0], trial_ge};
                dcnt_next = dcnt_reg + DCNT_W'(1);
                if (dcnt_reg == DCNT_W'(NUM_W - 1))
                    res_value_next = Y_W'({acc_reg[NUM_W-2:0], trial_ge});
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = res_value_reg;
                    out_status_next = res_status_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            for (int c = 0; c < NUM_CHANNELS; c++)
                count_reg[c] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_mode_reg <= s_axis_tuser[MODE_W-1:0];
            cmd_ch_reg   <= s_axis_tuser[MODE_W +: CH_W];
            cmd_x_reg    <= s_axis_tdata[X_W-1:0];
            cmd_y_reg    <= s_axis_tdata[X_W +: Y_W];
        end
        pos_reg        <= pos_next;
        k_reg          <= k_next;
        prev_reg       <= prev_next;
        left_reg       <= left_next;
        right_reg      <= right_next;
        acc_reg        <= acc_next;
        rem_reg        <= rem_next;
        dcnt_reg       <= dcnt_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

    // point store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[mem_raddr];
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DATA_W'(out_value_reg);
    assign m_axis_tuser  = out_status_reg;

    always_comb
    begin
        cnt_in_range = 1'b1;
        for (int c = 0; c < NUM_CHANNELS; c++)
            if (count_reg[c] > CNT_W'(MAX_POINTS))
                cnt_in_range = 1'b0;
    end

    `TFI_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, cnt_in_range)
    `TFI_ASSERT_NEXT(a_accept_decode, clk, rst_n, accept, state_reg == ST_DECODE)
    `TFI_ASSERT_IMPL(a_walk_no_write, clk, rst_n, state_reg == ST_EV_WALK, !mem_we)
    `TFI_ASSERT_IMPL(a_rise_from_out, clk, rst_n, $rose(m_axis_tvalid), $past(state_reg == ST_OUT))
    `TFI_ASSERT_IMPL(a_drop_zero, clk, rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0)

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking bench for transfer_function_interpolator_unit: streams clear, add,
// evaluate and unused-mode words, predicts every output word and checks it.
// Depends on tfi_pkg and the top level RTL.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import tfi_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [CH_W-1:0]   ch;
        logic [X_W-1:0]    x;
        logic [Y_W-1:0]    v;
    } lut_cmd_t;

    typedef struct packed {
        logic [Y_W-1:0] value;
        logic           status;
    } lut_word_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [IN_USER_W-1:0]  s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;

    lut_cmd_t  pending_cmds[$];
    lut_word_t expected_words[$];
    lut_cmd_t  cur_cmd;
    int        words_in = 0;
    int        fails = 0;
    int        send_idle;
    int        recv_idle;
    int        hold_left = 0;
    logic      pressure_done = 1'b0;

    logic [X_W-1:0] pt_x[NUM_CHANNELS][MAX_POINTS];
    logic [Y_W-1:0] pt_y[NUM_CHANNELS][MAX_POINTS];
    int             pt_count[NUM_CHANNELS];

    transfer_function_interpolator_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("Verification failed");
        $finish;
    end

    assign send_idle = (words_in < 560) ? 10 : (words_in < 1120) ? 73 : 0;
    assign recv_idle = (words_in < 560) ? 73 : (words_in < 1120) ? 10 : 0;

    function automatic logic [Y_W-1:0] lut_value(int ch, int idx);
        int xs[MAX_POINTS+2];
        int ys[MAX_POINTS+2];
        int m, n, k, seg, x0, x1, y0, y1, d;
        n = pt_count[ch];
        if (n == 0)
            return '0;
        m = 0;
        if (pt_x[ch][0] != 0)
        begin
            xs[0] = 0;
            ys[0] = pt_y[ch][0];
            m = 1;
        end
        for (k = 0; k < n; k++)
        begin
            xs[m] = pt_x[ch][k];
            ys[m] = pt_y[ch][k];
            m++;
        end
        if (xs[m-1] != int'(TOP_INDEX))
        begin
            xs[m] = TOP_INDEX;
            ys[m] = ys[m-1];
            m++;
        end
        seg = 0;
        while (seg + 2 < m && idx > xs[seg+1])
            seg++;
        x0 = xs[seg];
        x1 = xs[seg+1];
        y0 = ys[seg];
        y1 = ys[seg+1];
        if (x1 <= x0 || idx <= x0)
            return Y_W'(y0);
        if (idx >= x1)
            return Y_W'(y1);
        d = x1 - x0;
        return Y_W'(((x1 - idx) * y0 + (idx - x0) * y1 + d / 2) / d);
    endfunction

    function automatic void apply_cmd(lut_cmd_t c);
        lut_word_t r;
        int ch, pos;
        r = '0;
        ch = c.ch;
        if (ch < NUM_CHANNELS)
        begin
            if (c.mode == MODE_CLEAR)
                pt_count[ch] = 0;
            else if (c.mode == MODE_ADD)
            begin
                if (pt_count[ch] >= MAX_POINTS)
                    r.status = 1'b1;
                else
                begin
                    pos = pt_count[ch];
                    while (pos > 0 && pt_x[ch][pos-1] > c.x)
                    begin
                        pt_x[ch][pos] = pt_x[ch][pos-1];
                        pt_y[ch][pos] = pt_y[ch][pos-1];
                        pos--;
                    end
                    pt_x[ch][pos] = c.x;
                    pt_y[ch][pos] = (c.v > Q12_ONE) ? Q12_ONE : c.v;
                    pt_count[ch]++;
                end
            end
            else if (c.mode == MODE_EVAL)
                r.value = lut_value(ch, c.x);
        end
        expected_words = {expected_words, r};
    endfunction

    function automatic void push_cmd(logic [MODE_W-1:0] mode, int ch, int x, int v);
        lut_cmd_t c;
        c.mode = mode;
        c.ch   = CH_W'(ch);
        c.x    = X_W'(x);
        c.v    = Y_W'(v);
        pending_cmds = {pending_cmds, c};
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : drive
        lut_cmd_t nxt;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
            for (int c = 0; c < NUM_CHANNELS; c++)
                pt_count[c] = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                apply_cmd(cur_cmd);
                words_in <= words_in + 1;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle)
                begin
                    nxt = pending_cmds.pop_front();
                    cur_cmd       <= nxt;
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= IN_DATA_W'({nxt.v, nxt.x});
                    s_axis_tuser  <= {nxt.ch, nxt.mode};
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // hold off once for a long stretch so the block backs up into its input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= 0;
            pressure_done <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end
        else if (!pressure_done && words_in >= 200)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= 400;
            pressure_done <= 1'b1;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge clk)
    begin : watch
        lut_word_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, got value %0d status %0d",
                         $time, m_axis_tdata[Y_W-1:0], m_axis_tuser);
                fails++;
            end
            else
            begin
                want = expected_words.pop_front();
                if (m_axis_tdata[Y_W-1:0] !== want.value)
                begin
                    $display("%0t: result_value mismatch, expected %0d, got %0d",
                             $time, want.value, m_axis_tdata[Y_W-1:0]);
                    fails++;
                end
                if (m_axis_tuser !== want.status)
                begin
                    $display("%0t: status mismatch, expected %0d, got %0d",
                             $time, want.status, m_axis_tuser);
                    fails++;
                end
            end
        end
    end

    initial
    begin : stimulus
        int rand_words, k, npts, nev, ch, xv, pick;
        int seq_x[$];
        logic [MODE_W-1:0] md;

        // empty channel, end points, saturation, interpolation
        push_cmd(MODE_EVAL, 0, 0, 8191);
        push_cmd(MODE_ADD, 0, 0, 0);
        push_cmd(MODE_ADD, 0, 255, 8191);
        push_cmd(MODE_EVAL, 0, 128, 0);
        push_cmd(MODE_EVAL, 0, 255, 0);
        // equal intensities, implicit ends, unused mode, clear
        push_cmd(MODE_ADD, 1, 100, 4096);
        push_cmd(MODE_ADD, 1, 100, 1000);
        push_cmd(MODE_EVAL, 1, 100, 0);
        push_cmd(MODE_EVAL, 1, 40, 0);
        push_cmd(MODE_UNUSED, 2, 255, 8191);
        push_cmd(MODE_CLEAR, 0, 0, 0);
        push_cmd(MODE_EVAL, 0, 10, 0);
        // fill a channel in falling order, then overflow it
        for (k = 14; k >= 1; k--)
            push_cmd(MODE_ADD, 1, k * 17, k * 290);
        push_cmd(MODE_ADD, 1, 7, 123);
        push_cmd(MODE_EVAL, 1, 120, 0);

        rand_words = 0;
        while (rand_words < 1650)
        begin
            if ($urandom_range(9) < 8)
            begin
                ch = $urandom_range(NUM_CHANNELS - 1);
                seq_x.delete();
                if ($urandom_range(3) != 0)
                begin
                    push_cmd(MODE_CLEAR, ch, $urandom_range(255), $urandom_range(8191));
                    rand_words++;
                end
                npts = $urandom_range(18);
                for (k = 0; k < npts; k++)
                begin
                    pick = $urandom_range(7);
                    if (pick == 0)
                        xv = 0;
                    else if (pick == 1)
                        xv = 255;
                    else if (pick == 2 && seq_x.size() > 0)
                        xv = seq_x[$urandom_range(seq_x.size() - 1)];
                    else
                        xv = $urandom_range(255);
                    seq_x = {seq_x, xv};
                    push_cmd(MODE_ADD, ch, xv, ($urandom_range(4) == 0) ?
                             $urandom_range(4097, 8191) : $urandom_range(4096));
                    rand_words++;
                end
                nev = $urandom_range(1, 8);
                for (k = 0; k < nev; k++)
                begin
                    pick = $urandom_range(7);
                    if (pick < 2 && seq_x.size() > 0)
                        xv = seq_x[$urandom_range(seq_x.size() - 1)];
                    else if (pick == 2)
                        xv = 0;
                    else if (pick == 3)
                        xv = 255;
                    else
                        xv = $urandom_range(255);
                    push_cmd(MODE_EVAL, ch, xv, $urandom_range(8191));
                    rand_words++;
                end
            end
            else
            begin
                npts = $urandom_range(1, 4);
                for (k = 0; k < npts; k++)
                begin
                    md = MODE_W'($urandom_range(3));
                    push_cmd(md, $urandom_range(3), $urandom_range(255), $urandom_range(8191));
                    if (md != MODE_UNUSED)
                        rand_words++;
                end
            end
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_cmds.size() > 0 || s_axis_tvalid)
            @(posedge clk);
        while (expected_words.size() > 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        if (fails == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
